// ----- rtl/tmt_pkg.sv -----
// Package for the timer slot table: field widths, command and status codes,
// default sizes and the write-control struct of the slot memory.
// No dependencies; every other file in rtl/ imports it.
`timescale 1ns / 1ps

package tmt_pkg;

  localparam int NumSlotsDef = 32;
  localparam int TimeBitsDef = 32;
  localparam int MaxFires    = 32;

  localparam int CmdW    = 3;
  localparam int SlotIdW = 6;
  localparam int PeriodW = 32;
  localparam int NowW    = 32;
  localparam int StatusW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_CREATE  = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_DELETE  = 3'd3,
    CMD_PROCESS = 3'd4
  } cmd_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ID    = 2'd1,
    ST_NOT_ALLOC = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Write enables of the slot memory; both write the same slot.
  typedef struct packed {
    logic cfg_we;  // period and repeat flag
    logic dl_we;   // deadline
  } slot_wr_t;

  // Bits of a slot index; at least one so that a one-slot table still has a port.
  function automatic int idx_bits(int n);
    int b;
    b = (n > 1) ? $clog2(n) : 1;
    return b;
  endfunction

endpackage

// ----- rtl/tmt_time_alu.sv -----
// Shared time unit of the timer slot table: one adder for re-arming and one
// unsigned compare for expiry. Depends on tmt_pkg.
`timescale 1ns / 1ps

module tmt_time_alu import tmt_pkg::*; #(
  parameter int TIME_BITS = TimeBitsDef
) (
  input  logic [TIME_BITS-1:0] now,
  input  logic [PeriodW-1:0]   period,
  input  logic [TIME_BITS-1:0] deadline,
  output logic [TIME_BITS-1:0] rearm,
  output logic                 due
);

  // The sum wraps at the time width; a result of zero leaves the slot stopped.
  assign rearm = now + TIME_BITS'(period);

  // A deadline of zero marks a stopped slot and never expires.
  assign due = (deadline != '0) && (now >= deadline);

endmodule

// ----- rtl/tmt_slot_ram.sv -----
// Slot memory of the timer slot table: period, repeat flag and deadline per
// slot, one write and one registered read per cycle. Depends on tmt_pkg.
`timescale 1ns / 1ps

module tmt_slot_ram import tmt_pkg::*; #(
  parameter int NUM_SLOTS = NumSlotsDef,
  parameter int TIME_BITS = TimeBitsDef
) (
  input  logic                             clk,
  input  slot_wr_t                         wr,
  input  logic [idx_bits(NUM_SLOTS)-1:0]   wr_addr,
  input  logic [PeriodW-1:0]               wr_period,
  input  logic                             wr_periodic,
  input  logic [TIME_BITS-1:0]             wr_deadline,
  input  logic [idx_bits(NUM_SLOTS)-1:0]   rd_addr,
  output logic [PeriodW-1:0]               rd_period,
  output logic                             rd_periodic,
  output logic [TIME_BITS-1:0]             rd_deadline
);

  logic [PeriodW-1:0]   period_mem   [NUM_SLOTS];
  logic                 periodic_mem [NUM_SLOTS];
  logic [TIME_BITS-1:0] dl_mem       [NUM_SLOTS];

  // Contents are not cleared: a slot's contents are only used while it is allocated, and
  // allocation always writes all three fields first.
  always_ff @(posedge clk) begin
    if (wr.cfg_we) begin
      period_mem[wr_addr]   <= wr_period;
      periodic_mem[wr_addr] <= wr_periodic;
    end
    if (wr.dl_we) begin
      dl_mem[wr_addr] <= wr_deadline;
    end
    rd_period   <= period_mem[rd_addr];
    rd_periodic <= periodic_mem[rd_addr];
    rd_deadline <= dl_mem[rd_addr];
  end

endmodule

// ----- rtl/multi_slot_timer_table.sv -----
// Timer slot table: a sequencer walks the slot memory one slot per cycle through one read port,
// holding while a fired result cannot be queued, and shares a single adder/compare unit; one
// transaction is in flight at a time. Start, stop and delete read their slot and answer from it;
// rejected commands go straight to the response state; create scans from slot 0 up to the lowest
// free slot; process scans every slot, or stops early after MaxFires expiries.
// Synchronous reset frees all slots and clears the count; the slot memory is not cleared.
`timescale 1ns / 1ps

module multi_slot_timer_table import tmt_pkg::*; #(
  parameter int NUM_SLOTS = NumSlotsDef,
  parameter int TIME_BITS = TimeBitsDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CmdW-1:0]    command,
  input  logic [SlotIdW-1:0] slot_id,
  input  logic [PeriodW-1:0] period,
  input  logic               periodic,
  input  logic [NowW-1:0]    now_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [StatusW-1:0] status,
  output logic [SlotIdW-1:0] result_id,
  output logic               fired,
  output logic               last_result
);

  localparam int IdxW  = idx_bits(NUM_SLOTS);
  localparam int CntW  = $clog2(NUM_SLOTS + 1);
  localparam int FireW = $clog2(MaxFires + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACCESS,
    S_RESP,
    S_FINISH
  } state_t;

  state_t               state;
  cmd_t                 cmd_q;
  logic [SlotIdW-1:0]   id_q;
  logic [PeriodW-1:0]   period_q;
  logic                 periodic_q;
  logic [TIME_BITS-1:0] now_q;
  logic [IdxW-1:0]      eval_idx;
  logic [IdxW-1:0]      eval_next;
  logic [FireW-1:0]     fire_cnt;
  logic                 pend_vld;
  logic [SlotIdW-1:0]   pend_id;
  status_t              resp_status;
  logic [SlotIdW-1:0]   resp_id;
  logic [NUM_SLOTS-1:0] alloc;
  logic [CntW-1:0]      in_use;

  cmd_t                 cmd_in;
  logic                 accept;
  logic                 out_free;
  logic                 id_ok;
  logic                 is_access;
  logic [IdxW-1:0]      id_idx;
  logic                 cur_alloc;
  logic [SlotIdW-1:0]   eval_id;
  logic                 last_slot;
  logic [FireW-1:0]     fire_cnt_inc;
  logic                 cap_hit;
  logic                 fire;
  logic                 advance;

  slot_wr_t             wr;
  logic [TIME_BITS-1:0] wr_deadline;
  logic [PeriodW-1:0]   rd_period;
  logic                 rd_periodic;
  logic [TIME_BITS-1:0] rd_deadline;
  logic [PeriodW-1:0]   alu_period;
  logic [TIME_BITS-1:0] rearm;
  logic                 due;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cmd_in    = cmd_t'(command);
  assign is_access = (cmd_in == CMD_START) || (cmd_in == CMD_STOP) ||
                     (cmd_in == CMD_DELETE);
  assign id_ok     = (slot_id != '0) &&
                     ({1'b0, slot_id} <= (SlotIdW + 1)'(NUM_SLOTS));
  assign id_idx    = IdxW'(slot_id - SlotIdW'(1));

  assign cur_alloc    = alloc[eval_idx];
  assign eval_id      = SlotIdW'(eval_idx) + SlotIdW'(1);
  assign last_slot    = (eval_idx == LastIdx);
  assign fire_cnt_inc = fire_cnt + FireW'(1);
  assign cap_hit      = (fire_cnt_inc == FireW'(MaxFires));

  // Create uses the period of the transaction, start and process the stored one.
  assign alu_period = (cmd_q == CMD_CREATE) ? period_q : rd_period;

  tmt_time_alu #(
    .TIME_BITS (TIME_BITS)
  ) u_alu (
    .now      (now_q),
    .period   (alu_period),
    .deadline (rd_deadline),
    .rearm    (rearm),
    .due      (due)
  );

  assign fire = cur_alloc && due;

  // The scan moves on unless it ends here or the fired result cannot be queued.
  always_comb begin
    advance = 1'b0;
    if (state == S_SCAN) begin
      if (cmd_q == CMD_CREATE) begin
        advance = cur_alloc && !last_slot;
      end else if (fire) begin
        advance = (!pend_vld || out_free) && !cap_hit && !last_slot;
      end else begin
        advance = !last_slot;
      end
    end
  end

  // The read address is always the slot evaluated in the next cycle.
  always_comb begin
    eval_next = eval_idx;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          eval_next = (is_access && id_ok) ? id_idx : '0;
        end
      end
      S_SCAN: begin
        if (advance) begin
          eval_next = eval_idx + IdxW'(1);
        end
      end
      default: eval_next = eval_idx;
    endcase
  end

  always_comb begin
    wr          = '0;
    wr_deadline = rearm;
    unique case (state)
      S_SCAN: begin
        if (cmd_q == CMD_CREATE) begin
          if (!cur_alloc && out_free) begin
            wr.cfg_we = 1'b1;
            wr.dl_we  = 1'b1;
          end
        end else if (fire && (!pend_vld || out_free)) begin
          wr.dl_we    = 1'b1;
          wr_deadline = rd_periodic ? rearm : '0;
        end
      end
      S_ACCESS: begin
        if (out_free && cur_alloc) begin
          if (cmd_q == CMD_START) begin
            wr.dl_we = 1'b1;
          end else if (cmd_q == CMD_STOP) begin
            wr.dl_we    = 1'b1;
            wr_deadline = '0;
          end
        end
      end
      default: wr = '0;
    endcase
  end

  tmt_slot_ram #(
    .NUM_SLOTS (NUM_SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_ram (
    .clk         (clk),
    .wr          (wr),
    .wr_addr     (eval_idx),
    .wr_period   (period_q),
    .wr_periodic (periodic_q),
    .wr_deadline (wr_deadline),
    .rd_addr     (eval_next),
    .rd_period   (rd_period),
    .rd_periodic (rd_periodic),
    .rd_deadline (rd_deadline)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pend_vld  <= 1'b0;
      fire_cnt  <= '0;
      alloc     <= '0;
      in_use    <= '0;
    end else begin
      eval_idx <= eval_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q      <= cmd_in;
            id_q       <= slot_id;
            period_q   <= period;
            periodic_q <= periodic;
            now_q      <= TIME_BITS'(now_time);
            fire_cnt   <= '0;
            pend_vld   <= 1'b0;
            if (cmd_in == CMD_CREATE) begin
              if (in_use >= CntW'(NUM_SLOTS)) begin
                resp_status <= ST_FULL;
                resp_id     <= '0;
                state       <= S_RESP;
              end else begin
                state <= S_SCAN;
              end
            end else if (cmd_in == CMD_PROCESS) begin
              state <= S_SCAN;
            end else if (is_access) begin
              if (id_ok) begin
                state <= S_ACCESS;
              end else begin
                resp_status <= ST_BAD_ID;
                resp_id     <= slot_id;
                state       <= S_RESP;
              end
            end else begin
              resp_status <= ST_BAD_ID;
              resp_id     <= '0;
              state       <= S_RESP;
            end
          end
        end

        S_SCAN: begin
          if (cmd_q == CMD_CREATE) begin
            if (!cur_alloc) begin
              if (out_free) begin
                alloc[eval_idx] <= 1'b1;
                in_use          <= in_use + CntW'(1);
                out_valid       <= 1'b1;
                status          <= ST_OK;
                result_id       <= eval_id;
                fired           <= 1'b0;
                last_result     <= 1'b1;
                state           <= S_IDLE;
              end
            end else if (last_slot) begin
              resp_status <= ST_FULL;
              resp_id     <= '0;
              state       <= S_RESP;
            end
          end else if (fire) begin
            // A fired slot waits in the pending register until it is known
            // whether another slot fires after it.
            if (!pend_vld || out_free) begin
              if (pend_vld) begin
                out_valid   <= 1'b1;
                status      <= ST_OK;
                result_id   <= pend_id;
                fired       <= 1'b1;
                last_result <= 1'b0;
              end
              pend_vld <= 1'b1;
              pend_id  <= eval_id;
              fire_cnt <= fire_cnt_inc;
              if (cap_hit || last_slot) begin
                state <= S_FINISH;
              end
            end
          end else if (last_slot) begin
            state <= S_FINISH;
          end
        end

        S_ACCESS: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            result_id   <= id_q;
            fired       <= 1'b0;
            last_result <= 1'b1;
            if (!cur_alloc) begin
              status <= ST_NOT_ALLOC;
            end else begin
              status <= ST_OK;
              if (cmd_q == CMD_DELETE) begin
                alloc[eval_idx] <= 1'b0;
                if (in_use != '0) begin
                  in_use <= in_use - CntW'(1);
                end
              end
            end
            state <= S_IDLE;
          end
        end

        S_RESP: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= resp_status;
            result_id   <= resp_id;
            fired       <= 1'b0;
            last_result <= 1'b1;
            state       <= S_IDLE;
          end
        end

        S_FINISH: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= ST_OK;
            result_id   <= pend_vld ? pend_id : '0;
            fired       <= pend_vld;
            last_result <= 1'b1;
            pend_vld    <= 1'b0;
            state       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    in_use == CntW'($countones(alloc)))
    else $error("slot count differs from the number of allocated slots");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input taken again right after a transaction");

  a_pending_in_process: assert property (@(posedge clk) disable iff (rst)
    pend_vld |-> (cmd_q == CMD_PROCESS) && (state == S_SCAN || state == S_FINISH))
    else $error("pending fired result outside an expiry scan");

  a_fire_cap: assert property (@(posedge clk) disable iff (rst)
    fire_cnt <= FireW'(MaxFires))
    else $error("more expiries reported than allowed per transaction");

  a_fired_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && fired |-> status == ST_OK)
    else $error("fired result with an error status");

endmodule

// ----- verif/tb_multi_slot_timer_table.sv -----
// Self-checking testbench for multi_slot_timer_table: directed and random command traffic,
// with a scoreboard class that predicts every result and checks each one as it arrives.
// Depends on rtl/tmt_pkg.sv and rtl/multi_slot_timer_table.sv.
`timescale 1ns / 1ps

module tb_multi_slot_timer_table import tmt_pkg::*; ();

  localparam int SLOTS        = NumSlotsDef;
  localparam int TimeW        = TimeBitsDef;
  localparam int RandomItems  = 250;
  localparam int IdlePct      = 15;
  localparam int HoldCycles   = 400;
  localparam int DrainCycles  = NumSlotsDef + 8;
  localparam int TimeoutNs    = 2_000_000;
  localparam int MaxSlotCode  = 2**SlotIdW - 1;
  localparam int MaxCmdCode   = 2**CmdW - 1;

  typedef logic [SlotIdW-1:0] sid_t;
  typedef logic [TimeW-1:0]   tval_t;

  typedef struct {
    status_t st;
    sid_t    rid;
    logic    fired;
    logic    last;
  } timer_resp_t;

  function automatic sid_t rand_sid();
    return sid_t'($urandom);
  endfunction

  function automatic logic rand_bit();
    return ($urandom_range(1) == 1);
  endfunction

  // Tracks the slot table as the block should see it and holds the results still owed.
  class timer_table_checker;
    logic [PeriodW-1:0] arm_period [SLOTS];
    logic               repeats    [SLOTS];
    tval_t              due_at     [SLOTS];
    bit                 in_use     [SLOTS];
    int                 used_count;
    timer_resp_t        owed[$];
    int                 errors;

    function new();
      used_count = 0;
      errors     = 0;
      foreach (in_use[s]) begin
        in_use[s] = 0;
        due_at[s] = '0;
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void owe(status_t st, sid_t rid, logic f, logic l);
      timer_resp_t r;
      r.st    = st;
      r.rid   = rid;
      r.fired = f;
      r.last  = l;
      owed.push_back(r);
    endfunction

    function void log_command(logic [CmdW-1:0] cmd, sid_t sid, logic [PeriodW-1:0] per,
                              logic pdc, logic [NowW-1:0] now_in);
      tval_t now;
      int    s;
      int    n;
      bit    placed;
      now    = tval_t'(now_in);
      n      = 0;
      placed = 0;
      case (cmd)
        CMD_CREATE: begin
          if (used_count < SLOTS) begin
            for (s = 0; s < SLOTS && !placed; s++) begin
              if (!in_use[s]) begin
                in_use[s]     = 1;
                arm_period[s] = per;
                repeats[s]    = pdc;
                due_at[s]     = now + tval_t'(per);
                used_count++;
                owe(ST_OK, sid_t'(s + 1), 1'b0, 1'b1);
                placed = 1;
              end
            end
          end
          if (!placed) owe(ST_FULL, '0, 1'b0, 1'b1);
        end
        CMD_START, CMD_STOP, CMD_DELETE: begin
          if (sid == 0 || sid > SLOTS) begin
            owe(ST_BAD_ID, sid, 1'b0, 1'b1);
          end else if (!in_use[sid - 1]) begin
            owe(ST_NOT_ALLOC, sid, 1'b0, 1'b1);
          end else begin
            s = sid - 1;
            if (cmd == CMD_START) begin
              due_at[s] = now + tval_t'(arm_period[s]);
            end else if (cmd == CMD_STOP) begin
              due_at[s] = '0;
            end else begin
              in_use[s]     = 0;
              arm_period[s] = '0;
              repeats[s]    = 1'b0;
              due_at[s]     = '0;
              used_count--;
            end
            owe(ST_OK, sid, 1'b0, 1'b1);
          end
        end
        CMD_PROCESS: begin
          // A deadline of zero means stopped; the compare is plain unsigned.
          for (s = 0; s < SLOTS && n < MaxFires; s++) begin
            if (in_use[s] && due_at[s] != 0 && now >= due_at[s]) begin
              owe(ST_OK, sid_t'(s + 1), 1'b1, 1'b0);
              n++;
              due_at[s] = repeats[s] ? now + tval_t'(arm_period[s]) : '0;
            end
          end
          if (n == 0) owe(ST_OK, '0, 1'b0, 1'b1);
          else owed[owed.size() - 1].last = 1'b1;
        end
        default: begin
          owe(ST_BAD_ID, '0, 1'b0, 1'b1);
        end
      endcase
    endfunction

    function void check_result(logic [StatusW-1:0] st, sid_t rid, logic f, logic l);
      timer_resp_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: status %0d id %0d fired %0b last %0b",
                 $time, st, rid, f, l);
        return;
      end
      want = owed.pop_front();
      if (st !== want.st || rid !== want.rid || f !== want.fired || l !== want.last) begin
        errors++;
        $display(
          "%0t: expected status %0d id %0d fired %0b last %0b, actual %0d %0d %0b %0b",
          $time, want.st, want.rid, want.fired, want.last, st, rid, f, l);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [CmdW-1:0]    command;
  logic [SlotIdW-1:0] slot_id;
  logic [PeriodW-1:0] period;
  logic               periodic;
  logic [NowW-1:0]    now_time;
  logic               out_valid;
  logic               out_stall;
  logic [StatusW-1:0] status;
  logic [SlotIdW-1:0] result_id;
  logic               fired;
  logic               last_result;

  timer_table_checker board = new();
  int                 items_sent = 0;
  bit                 steady = 0;
  bit                 hold_req = 0;

  multi_slot_timer_table u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .slot_id    (slot_id),
    .period     (period),
    .periodic   (periodic),
    .now_time   (now_time),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .result_id  (result_id),
    .fired      (fired),
    .last_result(last_result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(TimeoutNs);
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: random stalls, a quiet stretch, and one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < IdlePct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_result(status, result_id, fired, last_result);
    end
  end

  // Presents one transaction and returns at the edge where it is taken.
  task automatic send_item(logic [CmdW-1:0] c, sid_t sid, logic [PeriodW-1:0] per,
                           logic pdc, logic [NowW-1:0] now);
    int gap;
    if (!steady && $urandom_range(99) < IdlePct) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= c;
    slot_id  <= sid;
    period   <= per;
    periodic <= pdc;
    now_time <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.log_command(c, sid, per, pdc, now);
    items_sent++;
  endtask

  // Stops offering input and waits until every owed result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    logic [NowW-1:0] cur;
    int              c;
    int              k;
    int              r;
    int              first_random;
    int              proc_run;
    int              top_id;
    sid_t            pick;
    bit              done_fill;
    bit              done_hold;
    bit              done_pause;
    bit              done_wrap;

    rst      <= 1'b1;
    in_valid <= 1'b0;
    command  <= CMD_CREATE;
    slot_id  <= '0;
    period   <= '0;
    periodic <= 1'b0;
    now_time <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, bad ids, unknown commands, zero and wrapping deadlines.
    send_item(CMD_PROCESS, rand_sid(), $urandom, rand_bit(), '0);
    send_item(CMD_START, '0, $urandom, rand_bit(), 32'd10);
    send_item(CMD_STOP, sid_t'(SLOTS + 1), $urandom, rand_bit(), 32'd10);
    send_item(CMD_DELETE, sid_t'(MaxSlotCode), $urandom, rand_bit(), 32'd10);
    send_item(CMD_START, sid_t'(1), $urandom, rand_bit(), 32'd10);
    for (c = int'(CMD_PROCESS) + 1; c <= MaxCmdCode; c++) begin
      send_item(CmdW'(c), rand_sid(), $urandom, rand_bit(), $urandom);
    end
    send_item(CMD_CREATE, rand_sid(), '0, 1'b0, '0);
    send_item(CMD_CREATE, rand_sid(), 32'd10, 1'b1, 32'd100);
    send_item(CMD_CREATE, rand_sid(), '1, 1'b0, 32'd5);
    send_item(CMD_PROCESS, rand_sid(), $urandom, rand_bit(), 32'd200);
    send_item(CMD_START, sid_t'(1), $urandom, rand_bit(), 32'd50);
    send_item(CMD_STOP, sid_t'(2), $urandom, rand_bit(), 32'd60);
    send_item(CMD_DELETE, sid_t'(3), $urandom, rand_bit(), 32'd60);
    send_item(CMD_DELETE, sid_t'(3), $urandom, rand_bit(), 32'd60);
    send_item(CMD_PROCESS, rand_sid(), $urandom, rand_bit(), '1);
    send_item(CMD_START, sid_t'(2), $urandom, rand_bit(), 32'hFFFF_FFF0);
    send_item(CMD_CREATE, rand_sid(), '0, 1'b1, '1);
    send_item(CMD_PROCESS, rand_sid(), $urandom, rand_bit(), '1);
    send_item(CMD_START, sid_t'(SLOTS), $urandom, rand_bit(), '1);
    // Now plus period wraps to zero here, which leaves the slot stopped.
    send_item(CMD_START, sid_t'(2), $urandom, rand_bit(), 32'hFFFF_FFF6);
    send_item(CMD_PROCESS, rand_sid(), $urandom, rand_bit(), '1);

    cur          = $urandom;
    first_random = items_sent;
    proc_run     = 0;
    done_fill    = 0;
    done_hold    = 0;
    done_pause   = 0;
    done_wrap    = 0;
    while (items_sent < first_random + RandomItems) begin
      k      = items_sent - first_random;
      steady = (k >= 150 && k < 200);
      if (!done_fill && k >= 60) begin
        // Fill every slot, ask once more for a full table, then let the newly created slots fire.
        done_fill = 1;
        while (board.used_count < SLOTS) begin
          send_item(CMD_CREATE, rand_sid(), $urandom_range(0, 50), rand_bit(), cur);
        end
        send_item(CMD_CREATE, rand_sid(), $urandom_range(0, 50), rand_bit(), cur);
        cur = cur + 60;
        send_item(CMD_PROCESS, rand_sid(), $urandom, rand_bit(), cur);
      end
      if (!done_hold && k >= 100) begin
        done_hold = 1;
        hold_req  = 1;
        proc_run  = 30;
      end
      if (!done_pause && k >= 140) begin
        done_pause = 1;
        drain();
      end
      if (!done_wrap && k >= 210) begin
        done_wrap = 1;
        cur       = 32'hFFFF_FFC0;
      end

      cur = cur + $urandom_range(0, 25);
      r   = $urandom_range(99);
      if (proc_run > 0) begin
        proc_run--;
        r = 70;
      end
      top_id = (board.used_count < SLOTS) ? board.used_count + 1 : SLOTS;
      pick   = ($urandom_range(9) == 0) ? sid_t'($urandom_range(MaxSlotCode))
                                        : sid_t'($urandom_range(1, top_id));
      if (r < 4) begin
        send_item(CmdW'($urandom_range(MaxCmdCode)), rand_sid(), $urandom,
                  rand_bit(), $urandom);
      end else if (r < 26) begin
        send_item(CMD_CREATE, rand_sid(),
                  ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 120),
                  rand_bit(), cur);
      end else if (r < 38) begin
        send_item(CMD_START, pick, $urandom, rand_bit(), cur);
      end else if (r < 46) begin
        send_item(CMD_STOP, pick, $urandom, rand_bit(), cur);
      end else if (r < 56) begin
        send_item(CMD_DELETE, pick, $urandom, rand_bit(), cur);
      end else if (r < 95) begin
        send_item(CMD_PROCESS, rand_sid(), $urandom, rand_bit(), cur);
      end else begin
        send_item(CmdW'($urandom_range(int'(CMD_PROCESS) + 1, MaxCmdCode)), rand_sid(),
                  $urandom, rand_bit(), $urandom);
      end
    end
    steady = 0;

    drain();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
